// File: sv/smm_pkg.sv
// Shared constants, command codes and types for the square matrix multiplier.
package smm_pkg;

    localparam int MAX_SIZE_DEF      = 32;
    localparam int ELEMENT_WIDTH_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int ROW_W   = 5;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 37;
    localparam int SIZE_W  = 6;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 2;

    localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_MATRIX_SIZE = 2'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET       = 6'd32;

    typedef struct packed {
        logic clear;
        logic vld;
    } t_mac_ctl;

endpackage

// File: sv/smm_if.sv
// Command and result channel interfaces of the matrix multiplier.
interface smm_cmd_if;
    import smm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic [ROW_W-1:0]          row;
    logic [ROW_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

interface smm_res_if;
    import smm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        out_row;
    logic [ROW_W-1:0]        out_col;
    logic signed [SUM_W-1:0] product_sum;

    modport source (output valid, out_row, out_col, product_sum, input ready);
    modport sink   (input valid, out_row, out_col, product_sum, output ready);
endinterface

// File: sv/square_matrix_multiply.sv
// Square matrix multiplier top level: element stores, dot-product sequencer, config port.
// Writes are taken back to back. An in-range compute item reads n elements of each memory,
// n = min(matrix_size, MAX_SIZE), and registers its result once the MAC has drained; the
// next item is taken once that result is loaded. One read of each element memory per cycle feeds one shared MAC.
// An out-of-range compute skips the reads and gives a zero result.
// Synchronous active-low reset clears control and sets matrix_size to 32, not the memories.
module square_matrix_multiply #(
    parameter int MAX_SIZE      = smm_pkg::MAX_SIZE_DEF,
    parameter int ELEMENT_WIDTH = smm_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    smm_cmd_if.sink                        i_cmd_ch,
    smm_res_if.source                      o_res_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smm_pkg::PADDR_W-1:0]    paddr,
    input  logic [smm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [smm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import smm_pkg::*;

    localparam int ELEM_W = (ELEMENT_WIDTH < VALUE_W) ? ELEMENT_WIDTH : VALUE_W;
    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_SIZE);
    localparam int N_W    = $clog2(MAX_SIZE + 1);
    localparam int CMP_W  = ((N_W > ROW_W) ? N_W : ROW_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [SIZE_W-1:0] r_size;
    logic [N_W-1:0]    w_n;
    logic [N_W-1:0]    r_k, n_k;
    logic [ROW_W-1:0]  r_row, r_col;
    logic              r_rd_vld;

    logic r_out_vld, n_out_vld;
    logic [ROW_W-1:0]        r_out_row, r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;

    logic w_accept, w_in_store, w_in_range, w_wr_a, w_wr_b, w_cfg_wr;
    logic w_out_free, w_pipe_empty, w_load_out;
    logic [ADDR_W-1:0] w_waddr, w_a_raddr, w_b_raddr;
    logic [IDX_W-1:0]  w_k_idx;
    logic [ELEM_W-1:0] w_a_rdata, w_b_rdata;

    t_mac_ctl                w_mac_ctl;
    logic                    w_mac_busy;
    logic signed [SUM_W-1:0] w_mac_acc;

    // ---------------------------------------------------------------- config
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MATRIX_SIZE);
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_MATRIX_SIZE) ? APB_DATA_W'(r_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    // Saturate the configured size to the storage size.
    assign w_n = (CMP_W'(r_size) > CMP_W'(MAX_SIZE)) ? N_W'(MAX_SIZE) : N_W'(r_size);

    // ---------------------------------------------------------------- input
    assign i_cmd_ch.ready = (r_state == S_IDLE);
    assign w_accept       = i_cmd_ch.valid && i_cmd_ch.ready;

    assign w_in_store = (CMP_W'(i_cmd_ch.row) < CMP_W'(MAX_SIZE)) &&
                        (CMP_W'(i_cmd_ch.col) < CMP_W'(MAX_SIZE));
    assign w_in_range = (CMP_W'(i_cmd_ch.row) < CMP_W'(w_n)) &&
                        (CMP_W'(i_cmd_ch.col) < CMP_W'(w_n));

    // Writes land only in idle, read data is used only while computing: the ready interlock
    // keeps a write from ever meeting a read whose data is used in one cycle.
    assign w_wr_a  = w_accept && (i_cmd_ch.cmd == CMD_WR_A) && w_in_store;
    assign w_wr_b  = w_accept && (i_cmd_ch.cmd == CMD_WR_B) && w_in_store;
    assign w_waddr = ADDR_W'(i_cmd_ch.row) * ADDR_W'(MAX_SIZE) + ADDR_W'(i_cmd_ch.col);

    // ---------------------------------------------------------------- memories
    assign w_k_idx   = r_k[IDX_W-1:0];
    assign w_a_raddr = ADDR_W'(r_row) * ADDR_W'(MAX_SIZE) + ADDR_W'(w_k_idx);
    assign w_b_raddr = ADDR_W'(w_k_idx) * ADDR_W'(MAX_SIZE) + ADDR_W'(r_col);

    smm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_a),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd_ch.value[ELEM_W-1:0]),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    smm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_b),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd_ch.value[ELEM_W-1:0]),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // ---------------------------------------------------------------- MAC
    assign w_mac_ctl.clear = w_accept && (i_cmd_ch.cmd == CMD_COMPUTE);
    assign w_mac_ctl.vld   = r_rd_vld;

    smm_mac #(.ELEM_W(ELEM_W)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     ($signed(w_a_rdata)),
        .i_b     ($signed(w_b_rdata)),
        .o_busy  (w_mac_busy),
        .o_acc   (w_mac_acc)
    );

    // ---------------------------------------------------------------- sequencer
    assign w_out_free   = !r_out_vld || o_res_ch.ready;
    assign w_pipe_empty = !r_rd_vld && !w_mac_busy;
    assign w_load_out   = ((r_state == S_DRAIN) && w_pipe_empty && w_out_free) ||
                          ((r_state == S_HOLD) && w_out_free);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                n_k = '0;
                if (w_accept && (i_cmd_ch.cmd == CMD_COMPUTE)) begin
                    n_state = w_in_range ? S_READ : S_DRAIN;
                end
            end
            S_READ: begin
                n_k = r_k + 1'b1;
                if (n_k == w_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_pipe_empty) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_rd_vld <= (r_state == S_READ);
        end
    end

    // Hold the element coordinates for addressing and for the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= i_cmd_ch.row;
            r_col <= i_cmd_ch.col;
        end
    end

    // ---------------------------------------------------------------- output
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_res_ch.ready) begin
            n_out_vld = 1'b0;
        end
        if (w_load_out) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_out_sum <= w_mac_acc;
        end
    end

    assign o_res_ch.valid       = r_out_vld;
    assign o_res_ch.out_row     = r_out_row;
    assign o_res_ch.out_col     = r_out_col;
    assign o_res_ch.product_sum = r_out_sum;

    // ---------------------------------------------------------------- checks
    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !(w_wr_a || w_wr_b))
        else $error("element write while a dot product is in progress");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_k < w_n))
        else $error("inner index past matrix size");

    a_rd_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == S_READ))
        else $error("read data valid without an issued read");

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> w_pipe_empty)
        else $error("result loaded with products still in flight");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> w_out_free)
        else $error("result overwrites an untaken result");
endmodule

// File: sv/smm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/smm_mac.sv
// Multiply-accumulate unit: registered product, then exact wide accumulation.
module smm_mac #(
    parameter int ELEM_W = smm_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  smm_pkg::t_mac_ctl               i_ctl,
    input  logic signed [ELEM_W-1:0]        i_a,
    input  logic signed [ELEM_W-1:0]        i_b,
    output logic                            o_busy,
    output logic signed [smm_pkg::SUM_W-1:0] o_acc
);
    import smm_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [SUM_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prod <= i_a * i_b;
        end
    end

    // Sum wraps at SUM_W bits, never saturates.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    assign o_busy = r_prod_vld;
    assign o_acc  = r_acc;
endmodule
